// ----- sv/vector_rotate_by_two_angles_assert.svh -----
// Assertion macros shared by the rotation block.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef VECTOR_ROTATE_BY_TWO_ANGLES_ASSERT_SVH
`define VECTOR_ROTATE_BY_TWO_ANGLES_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VROT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VROT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/vrot_pkg.sv -----
// Shared types, widths and the quarter-wave sine table for the rotation block.
// No dependencies.
package vrot_pkg;

  localparam int SINE_DEPTH_LOG2  = 8;
  localparam int SINE_TABLE_DEPTH = 1 << SINE_DEPTH_LOG2;
  localparam int PHASE_W          = SINE_DEPTH_LOG2 + 2;

  localparam int ANGLE_W     = 16;
  localparam int COEF_W      = 17;
  localparam int VEC_W       = 32;
  localparam int PROD_W      = COEF_W + VEC_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int ROUND_SHIFT = 15;
  localparam int RND_W       = SUM_W - ROUND_SHIFT;

  localparam logic [COEF_W-1:0] SINE_ONE = 17'h08000;

  // radians per table step
  localparam real PHASE_STEP = 6.283185307179586476925 / (4.0 * SINE_TABLE_DEPTH);

  typedef logic [15:0]               rom_t [SINE_TABLE_DEPTH];
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [VEC_W-1:0]   vec_t;

  // stage loads driven by the top-level pipeline control into each lane
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctl_t;

  // entry k = round(sin(2*pi*k / (4*DEPTH)) * 32768), worked out at elaboration
  function automatic rom_t build_sine_rom();
    rom_t rom;
    real  x;
    int   k;
    for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x = PHASE_STEP * k;
      rom[k] = 16'($rtoi($floor($sin(x) * 32768.0 + 0.5)));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- sv/vrot_trig.sv -----
// Sine and cosine lookup of one angle from the quarter-wave table.
// Depends on vrot_pkg.
module vrot_trig import vrot_pkg::*; (
  input  logic [ANGLE_W-1:0] angle,
  output coef_t              sin_val,
  output coef_t              cos_val
);

  logic [PHASE_W-1:0]         phase;
  logic [1:0]                 quad;
  logic [SINE_DEPTH_LOG2-1:0] offs;

  // quadrants 1 and 3 read the table mirrored; offset zero there takes the
  // constant SINE_ONE, which is exactly one, in place of a table read
  function automatic coef_t sine_at(input logic [1:0] q,
                                    input logic [SINE_DEPTH_LOG2-1:0] o);
    logic [SINE_DEPTH_LOG2-1:0] rev;
    logic [COEF_W-1:0]          mag;
    rev = -o;
    if (q[0]) begin
      mag = (o == '0) ? SINE_ONE : {1'b0, SINE_ROM[rev]};
    end else begin
      mag = {1'b0, SINE_ROM[o]};
    end
    return q[1] ? coef_t'(-mag) : coef_t'(mag);
  endfunction

  assign phase = angle[ANGLE_W-1 -: PHASE_W];
  assign quad  = phase[PHASE_W-1 -: 2];
  assign offs  = phase[SINE_DEPTH_LOG2-1:0];

  assign sin_val = sine_at(quad, offs);
  assign cos_val = sine_at(quad + 2'd1, offs);

endmodule

// ----- sv/vrot_lane.sv -----
// One row of the rotation: three products, exact sum, round and clip.
// Depends on vrot_pkg; stage loads come from the top-level pipeline control.
module vrot_lane import vrot_pkg::*; (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  coef_t     coef_a,
  input  coef_t     coef_b,
  input  coef_t     coef_c,
  input  vec_t      vec_a,
  input  vec_t      vec_b,
  input  vec_t      vec_c,
  output vec_t      result,
  output logic      clip
);

  localparam logic signed [RND_W-1:0] MAX_VAL = RND_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [RND_W-1:0] MIN_VAL = ~MAX_VAL;

  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  biased;
  logic signed [RND_W-1:0]  rounded;
  logic                     over_hi;
  logic                     over_lo;

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_a <= coef_a * vec_a;
      prod_b <= coef_b * vec_b;
      prod_c <= coef_c * vec_c;
    end
    if (ctl.ld_sum) begin
      sum <= SUM_W'(prod_a) + SUM_W'(prod_b) + SUM_W'(prod_c);
    end
  end

  // round to nearest, ties towards plus infinity
  assign biased  = sum + SUM_W'(1 << (ROUND_SHIFT - 1));
  assign rounded = biased[SUM_W-1:ROUND_SHIFT];
  assign over_hi = rounded > MAX_VAL;
  assign over_lo = rounded < MIN_VAL;
  assign clip    = over_hi | over_lo;

  always_comb begin
    if (over_hi) begin
      result = 32'sh7FFF_FFFF;
    end else if (over_lo) begin
      result = 32'sh8000_0000;
    end else begin
      result = rounded[VEC_W-1:0];
    end
  end

endmodule

// ----- sv/vector_rotate_by_two_angles.sv -----
// Rotation of a Q15.16 vector by the matrix built from two angles.
// Channels: an input request carries vec_x/vec_y/vec_z and the angles
// azimuth and zenith; it is taken on a rising edge with in_valid high and
// in_stall low. A result request carries out_x/out_y/out_z and saturated,
// and is taken on an edge with out_valid high and out_stall low.
// An accepted request is registered in stage 1 and leaves stage 5 as out_valid.
// Throughput: one request per cycle while out_stall is low; the five
// pipeline stages (table lookup, matrix products, three row lanes of
// products, lane sums, output merge) each hold one request.
// The three lanes each form one output row; the merge stage registers the
// clipped components and ORs the lane clip flags into saturated.
// Stall: each stage advances when it is empty or its successor advances, so
// bubbles are squeezed out while out_stall is high; in_stall rises only when
// every stage holds a request. A stalled result holds its value.
// Reset (rst, synchronous) empties the pipeline; no clearing pass is needed.
`include "vector_rotate_by_two_angles_assert.svh"
module vector_rotate_by_two_angles import vrot_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vec_t               vec_x,
  input  vec_t               vec_y,
  input  vec_t               vec_z,
  input  logic [ANGLE_W-1:0] azimuth,
  input  logic [ANGLE_W-1:0] zenith,
  output logic               out_valid,
  input  logic               out_stall,
  output vec_t               out_x,
  output vec_t               out_y,
  output vec_t               out_z,
  output logic               saturated
);

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  coef_t st_now, ct_now, sp_now, cp_now;
  coef_t st1, ct1, sp1, cp1;
  vec_t  vx1, vy1, vz1;
  vec_t  vx2, vy2, vz2;
  coef_t m2 [3][3];

  lane_ctl_t ctl;
  vec_t      lane_res  [3];
  logic      lane_clip [3];

  logic stages_full;
  logic out_extreme;

  function automatic coef_t round_q15(input coef_t a, input coef_t b);
    logic signed [2*COEF_W-1:0] prod;
    logic signed [2*COEF_W-1:0] biased;
    prod   = a * b;
    biased = prod + (2*COEF_W)'(1 << (ROUND_SHIFT - 1));
    return biased[COEF_W+ROUND_SHIFT-1:ROUND_SHIFT];
  endfunction

  // ready chain: a stage can take a request when empty or when it moves on
  assign rdy5     = !v5 || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign ctl.ld_prod = v2 && rdy3;
  assign ctl.ld_sum  = v3 && rdy4;

  vrot_trig u_trig_az (.angle(azimuth), .sin_val(st_now), .cos_val(ct_now));
  vrot_trig u_trig_ze (.angle(zenith),  .sin_val(sp_now), .cos_val(cp_now));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      vx1 <= vec_x;
      vy1 <= vec_y;
      vz1 <= vec_z;
      st1 <= st_now;
      ct1 <= ct_now;
      sp1 <= sp_now;
      cp1 <= cp_now;
    end
    if (v1 && rdy2) begin
      vx2      <= vx1;
      vy2      <= vy1;
      vz2      <= vz1;
      m2[0][0] <= round_q15(ct1, cp1);
      m2[0][1] <= round_q15(st1, cp1);
      m2[0][2] <= -sp1;
      m2[1][0] <= -st1;
      m2[1][1] <= ct1;
      m2[1][2] <= '0;
      m2[2][0] <= round_q15(ct1, sp1);
      m2[2][1] <= round_q15(st1, sp1);
      m2[2][2] <= cp1;
    end
    if (v4 && rdy5) begin
      out_x     <= lane_res[0];
      out_y     <= lane_res[1];
      out_z     <= lane_res[2];
      saturated <= lane_clip[0] | lane_clip[1] | lane_clip[2];
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_lane
    vrot_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coef_a (m2[r][0]),
      .coef_b (m2[r][1]),
      .coef_c (m2[r][2]),
      .vec_a  (vx2),
      .vec_b  (vy2),
      .vec_c  (vz2),
      .result (lane_res[r]),
      .clip   (lane_clip[r])
    );
  end

  assign out_valid = v5;

  assign stages_full = v1 && v2 && v3 && v4 && v5;
  assign out_extreme = out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
                       out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000 ||
                       out_z == 32'sh7FFF_FFFF || out_z == 32'sh8000_0000;

  `VROT_ASSERT_NOW(a_stall_only_when_full, in_stall, stages_full, "input stalled, stage empty")
  `VROT_ASSERT_NEXT(a_sum_held, v4 && !rdy5, v4 && v5, "lane sum lost while output held")
  `VROT_ASSERT_NOW(a_sat_has_extreme, out_valid && saturated, out_extreme, "saturated, no clip")

endmodule

// ----- sim/vector_rotate_by_two_angles_tb.sv -----
// Self-checking bench for vector_rotate_by_two_angles: random and directed vectors and angles,
// each result checked against an in-bench fixed-point rotation predictor.
// Depends on vrot_pkg (widths, vec_t) and the block itself.
`timescale 1ns / 1ps

module vector_rotate_by_two_angles_tb;
  import vrot_pkg::*;

  localparam int      CYCLE_LIMIT  = 1_000_000;
  localparam int      MAX_REPORTED = 10;
  localparam longint  FULL_TURN    = 4 * SINE_TABLE_DEPTH;
  localparam real     PI_VAL       = 3.14159265358979323846;
  localparam vec_t    VEC_MAX      = 32'sh7FFF_FFFF;
  localparam vec_t    VEC_MIN      = 32'sh8000_0000;
  localparam vec_t    ONE_Q16      = 32'sh0001_0000;
  localparam longint  OUT_MAX      = 64'sd2147483647;
  localparam longint  OUT_MIN      = -64'sd2147483648;

  typedef logic [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
    logic sat;
  } rotated_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  vec_t   vec_x = '0;
  vec_t   vec_y = '0;
  vec_t   vec_z = '0;
  angle_t azimuth = '0;
  angle_t zenith = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  vec_t   out_x;
  vec_t   out_y;
  vec_t   out_z;
  logic   saturated;

  longint   sine_mag [0:SINE_TABLE_DEPTH];
  rotated_t expected_rotations [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       idle_in = 1'b0;
  bit       stall_out = 1'b0;
  int       stall_left = 0;

  vector_rotate_by_two_angles dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .azimuth   (azimuth),
    .zenith    (zenith),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // quarter-wave magnitudes, one extra entry so that the peak reads as exactly 1.0
  initial begin
    real s;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      s = $floor($sin(PI_VAL * k / (2.0 * SINE_TABLE_DEPTH)) * 32768.0 + 0.5);
      if (s > 32768.0) s = 32768.0;
      sine_mag[k] = longint'($rtoi(s));
    end
  end

  function automatic longint signed_sine(longint idx);
    longint quad;
    longint off;
    longint m;
    quad = (idx / SINE_TABLE_DEPTH) & 3;
    off  = idx % SINE_TABLE_DEPTH;
    m    = (quad & 1) ? sine_mag[SINE_TABLE_DEPTH - off] : sine_mag[off];
    return (quad & 2) ? -m : m;
  endfunction

  // round to nearest at bit 15, ties towards plus infinity
  function automatic longint round_q15(longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic rotated_t rotate_vector(vec_t vx, vec_t vy, vec_t vz,
                                             angle_t theta, angle_t phi);
    longint   it, ip, st, ct, sp, cp;
    longint   v [3];
    longint   mat [3][3];
    longint   acc;
    longint   comp [3];
    rotated_t res;
    v[0] = longint'(vx);
    v[1] = longint'(vy);
    v[2] = longint'(vz);
    it = (longint'(theta) * FULL_TURN) >> 16;
    ip = (longint'(phi) * FULL_TURN) >> 16;
    st = signed_sine(it);
    ct = signed_sine((it + SINE_TABLE_DEPTH) % FULL_TURN);
    sp = signed_sine(ip);
    cp = signed_sine((ip + SINE_TABLE_DEPTH) % FULL_TURN);
    mat[0][0] = round_q15(ct * cp);
    mat[0][1] = round_q15(st * cp);
    mat[0][2] = -sp;
    mat[1][0] = -st;
    mat[1][1] = ct;
    mat[1][2] = 0;
    mat[2][0] = round_q15(ct * sp);
    mat[2][1] = round_q15(st * sp);
    mat[2][2] = cp;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = round_q15(mat[i][0] * v[0] + mat[i][1] * v[1] + mat[i][2] * v[2]);
      if (acc > OUT_MAX) begin
        acc = OUT_MAX;
        res.sat = 1'b1;
      end else if (acc < OUT_MIN) begin
        acc = OUT_MIN;
        res.sat = 1'b1;
      end
      comp[i] = acc;
    end
    res.x = vec_t'(comp[0]);
    res.y = vec_t'(comp[1]);
    res.z = vec_t'(comp[2]);
    return res;
  endfunction

  // results are checked before the same edge's request is queued
  always @(posedge clk) begin : track_results
    rotated_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_rotations.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("unexpected result x=%0d y=%0d z=%0d sat=%0b",
                     out_x, out_y, out_z, saturated);
        end else begin
          want = expected_rotations.pop_front();
          if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
              saturated !== want.sat) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
              $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                       want.x, want.y, want.z, want.sat, out_x, out_y, out_z, saturated);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_rotations.push_back(rotate_vector(vec_x, vec_y, vec_z, azimuth, zenith));
    end
  end

  // result-side back-pressure: mostly short bursts, now and then a long hold
  always @(posedge clk) begin
    int r;
    if (rst || !stall_out) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else if (r < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic vec_t random_component();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return vec_t'($urandom);
      4, 5:       return vec_t'(int'($urandom_range(0, 2097152)) - 1048576);
      6:          return VEC_MAX - vec_t'($urandom_range(0, 255));
      default:    return VEC_MIN + vec_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic angle_t random_angle();
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4, 5: return angle_t'($urandom);
      6:       return angle_t'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 8)
                               - $urandom_range(0, 8));
      default: return angle_t'($urandom_range(0, 1023) << 6);
    endcase
  endfunction

  task automatic send_request(input vec_t x, input vec_t y, input vec_t z,
                              input angle_t az, input angle_t ze);
    int gap;
    gap = idle_in ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vec_x    <= x;
    vec_y    <= y;
    vec_z    <= z;
    azimuth  <= az;
    zenith   <= ze;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // one edge first so the last accepted request is already queued
  task automatic wait_all_returned();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rotations.size() != 0) @(posedge clk);
  endtask

  task automatic test_axis_and_extremes();
    idle_in   = 1'b1;
    stall_out = 1'b1;
    send_request('0, '0, '0, '0, '0);
    send_request(ONE_Q16, '0, '0, '0, '0);
    send_request(VEC_MAX, VEC_MIN, VEC_MAX, '0, '0);
    send_request(VEC_MAX, VEC_MAX, VEC_MAX, 16'hFFFF, 16'hFFFF);
    send_request(32'sd1, -32'sd1, 32'sd1, 16'h1555, 16'h2AAA);
    send_request(-32'sd1, 32'sd1, -32'sd1, 16'h003F, 16'h0040);
    send_request(ONE_Q16, ONE_Q16, ONE_Q16, 16'hAAAA, 16'h5555);
  endtask

  task automatic test_quadrant_edges();
    send_request(ONE_Q16, -ONE_Q16, ONE_Q16, 16'h4000, '0);
    send_request(ONE_Q16, -ONE_Q16, ONE_Q16, 16'h8000, 16'h4000);
    send_request(ONE_Q16, -ONE_Q16, ONE_Q16, 16'hC000, 16'h8000);
    send_request(ONE_Q16, -ONE_Q16, ONE_Q16, '0, 16'hC000);
    send_request(VEC_MAX, VEC_MIN, VEC_MIN, 16'h3FFF, 16'hBFFF);
    send_request(VEC_MIN, VEC_MAX, VEC_MAX, 16'h7FC0, 16'hFFC0);
  endtask

  task automatic test_saturation_edges();
    send_request(VEC_MAX, VEC_MAX, '0, 16'h2000, '0);
    send_request(VEC_MIN, VEC_MIN, '0, 16'h2000, '0);
    send_request(VEC_MIN, VEC_MAX, '0, 16'h2000, '0);
    send_request(VEC_MAX, '0, VEC_MAX, '0, 16'h2000);
    send_request(VEC_MAX, '0, VEC_MIN, '0, 16'hE000);
    send_request(VEC_MIN, VEC_MIN, VEC_MIN, 16'hFFFF, 16'hFFFF);
    wait_all_returned();
  endtask

  task automatic test_random_rotations(input int count);
    idle_in   = 1'b1;
    stall_out = 1'b1;
    repeat (count)
      send_request(random_component(), random_component(), random_component(),
                   random_angle(), random_angle());
  endtask

  // the sender holds off until the pipeline is empty between bursts
  task automatic test_drain_between_bursts(input int bursts);
    idle_in   = 1'b1;
    stall_out = 1'b1;
    repeat (bursts) begin
      repeat ($urandom_range(1, 12))
        send_request(random_component(), random_component(), random_component(),
                     random_angle(), random_angle());
      wait_all_returned();
    end
  endtask

  task automatic test_full_rate(input int count);
    idle_in   = 1'b0;
    stall_out = 1'b0;
    repeat (count)
      send_request(random_component(), random_component(), random_component(),
                   random_angle(), random_angle());
    wait_all_returned();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_axis_and_extremes();
    test_quadrant_edges();
    test_saturation_edges();
    test_random_rotations(500);
    test_drain_between_bursts(12);
    test_full_rate(200);
    test_random_rotations(550);

    wait_all_returned();
    stall_out = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_rotations.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/vrot_pkg.sv
sv/vrot_trig.sv
sv/vrot_lane.sv
sv/vector_rotate_by_two_angles.sv
sim/vector_rotate_by_two_angles_tb.sv
